/* rtl/ptdd_pkg.sv */
package ptdd_pkg;

  // Pulse counter width and the counter's saturation value
  localparam int unsigned COUNT_WIDTH = 11;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [7:0]             edge_ticks_t;
  typedef logic [15:0]            silence_ticks_t;
  typedef logic [3:0]             code_t;

  localparam count_t         COUNT_MAX   = '1;
  localparam edge_ticks_t    EDGE_MAX    = '1;
  localparam silence_ticks_t SILENCE_MAX = '1;

  // Register reset values
  localparam edge_ticks_t    LOCKOUT_RESET = 8'd40;
  localparam silence_ticks_t SILENCE_RESET = 16'd1000;

  // Register indexes
  localparam logic REG_LOCKOUT = 1'b0;
  localparam logic REG_SILENCE = 1'b1;

  // Denomination codes
  localparam code_t CODE_IDLE         = 4'd0;
  localparam code_t CODE_DENOM_1      = 4'd1;
  localparam code_t CODE_DENOM_2      = 4'd2;
  localparam code_t CODE_DENOM_3      = 4'd3;
  localparam code_t CODE_DENOM_4      = 4'd4;
  localparam code_t CODE_DENOM_5      = 4'd5;
  localparam code_t CODE_DENOM_6      = 4'd6;
  localparam code_t CODE_DENOM_7      = 4'd7;
  localparam code_t CODE_OUT_OF_RANGE = 4'd8;

  // Lower bound of the first band, then the upper bound of each pulse-count band
  localparam count_t BAND_MIN = COUNT_WIDTH'(3);
  localparam count_t BAND_1   = COUNT_WIDTH'(8);
  localparam count_t BAND_2   = COUNT_WIDTH'(15);
  localparam count_t BAND_3   = COUNT_WIDTH'(35);
  localparam count_t BAND_4   = COUNT_WIDTH'(85);
  localparam count_t BAND_5   = COUNT_WIDTH'(165);
  localparam count_t BAND_6   = COUNT_WIDTH'(350);
  localparam count_t BAND_7   = COUNT_WIDTH'(1000);

  // Configuration register set
  typedef struct packed {
    edge_ticks_t    lockout_ticks;
    silence_ticks_t silence_ticks;
  } cfg_t;

  // Map a pulse count to its denomination code
  function automatic code_t classify(count_t n);
    code_t c;
    if (n < BAND_MIN)       c = CODE_IDLE;
    else if (n <= BAND_1)   c = CODE_DENOM_1;
    else if (n <= BAND_2)   c = CODE_DENOM_2;
    else if (n <= BAND_3)   c = CODE_DENOM_3;
    else if (n <= BAND_4)   c = CODE_DENOM_4;
    else if (n <= BAND_5)   c = CODE_DENOM_5;
    else if (n <= BAND_6)   c = CODE_DENOM_6;
    else if (n <= BAND_7)   c = CODE_DENOM_7;
    else                    c = CODE_OUT_OF_RANGE;
    return c;
  endfunction

endpackage

/* rtl/pulse_train_denomination_decoder.sv */
// Channel   | Direction | Word layout (low bit first)
// ----------+-----------+---------------------------------------------
// s_axis    | in        | tdata[0] edge_req, tdata[1] poll, rest ignored
// m_axis    | out       | tdata[3:0] code, rest zero
// apb       | in        | 0x0 lockout_ticks, 0x4 silence_ticks
//
// One tick word per clock while the output is not stalled; an accepted
// word passes the input register, then the result register.
// The tick's state update and classification sit between those registers.
// Synchronous active-high reset clears the timers, pulse count and valids.
// A stalled output stops processing; the input register still takes one
// word while the result waits.
module pulse_train_denomination_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] edge_req, [1] poll
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptdd_pkg::*;

  cfg_t   cfg;
  code_t  code_comb;
  count_t pulse_total;
  logic   pulse_taken;

  logic   in_valid;
  logic   in_edge_req;
  logic   in_poll;
  logic   fire;
  logic   out_free;
  code_t  out_code;

  // Configuration registers
  ptdd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: result slot frees when empty or being taken
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_edge_req <= s_axis_tdata[0];
      in_poll     <= s_axis_tdata[1];
    end
  end

  // Tick processing
  ptdd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .edge_req    (in_edge_req),
    .poll        (in_poll),
    .cfg         (cfg),
    .code        (code_comb),
    .pulse_total (pulse_total),
    .pulse_taken (pulse_taken)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_code <= code_comb;
    end
  end

  assign m_axis_tdata = {4'd0, out_code};

`ifndef NO_ASSERTIONS
  // A decision that gives a non-idle code clears the pulse count
  a_decide_clears: assert property (@(posedge clk) disable iff (rst)
    fire && code_comb != CODE_IDLE |=> pulse_total == '0)
    else $error("pulse count not cleared after decision");

  // An accepted pulse can never be decided on the same tick
  a_no_decide_on_pulse: assert property (@(posedge clk) disable iff (rst)
    fire && pulse_taken |-> code_comb == CODE_IDLE)
    else $error("decision made on a tick with an accepted pulse");

  // Input stalls only when both stages are full and output is blocked
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  // A processed tick shows up at the output on the next cycle
  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_axis_tvalid)
    else $error("processed tick did not reach the output");
`endif

endmodule

/* rtl/ptdd_cfg.sv */
module ptdd_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ptdd_pkg::cfg_t    cfg
);
  import ptdd_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_ticks <= LOCKOUT_RESET;
      cfg.silence_ticks <= SILENCE_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LOCKOUT: cfg.lockout_ticks <= pwdata[7:0];
        REG_SILENCE: cfg.silence_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux; unused address bits are ignored
  always_comb begin
    case (reg_sel)
      REG_LOCKOUT: prdata = {24'd0, cfg.lockout_ticks};
      REG_SILENCE: prdata = {16'd0, cfg.silence_ticks};
      default:     prdata = '0;
    endcase
  end

endmodule

/* rtl/ptdd_core.sv */
module ptdd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             edge_req,
  input  logic             poll,
  input  ptdd_pkg::cfg_t   cfg,
  output ptdd_pkg::code_t  code,
  output ptdd_pkg::count_t pulse_total,
  output logic             pulse_taken
);
  import ptdd_pkg::*;

  edge_ticks_t    ticks_since_edge;
  silence_ticks_t ticks_since_pulse;

  edge_ticks_t    edge_inc;
  silence_ticks_t pulse_inc;
  count_t         total_mid;
  silence_ticks_t pulse_mid;
  logic           decide;

  edge_ticks_t    ticks_since_edge_next;
  silence_ticks_t ticks_since_pulse_next;
  count_t         pulse_total_next;

  // Tick update: timers advance, edge is filtered, then the poll decides
  always_comb begin
    edge_inc  = (ticks_since_edge != EDGE_MAX) ? ticks_since_edge + 8'd1 : ticks_since_edge;
    pulse_inc = (ticks_since_pulse != SILENCE_MAX) ?
                ticks_since_pulse + 16'd1 : ticks_since_pulse;

    pulse_taken = edge_req && (edge_inc > cfg.lockout_ticks);
    total_mid   = (pulse_taken && pulse_total != COUNT_MAX) ?
                  pulse_total + COUNT_WIDTH'(1) : pulse_total;
    pulse_mid   = pulse_taken ? '0 : pulse_inc;

    decide = poll && (total_mid != '0) && (pulse_mid > cfg.silence_ticks);
    code   = decide ? classify(total_mid) : CODE_IDLE;

    ticks_since_edge_next  = edge_req ? '0 : edge_inc;
    ticks_since_pulse_next = pulse_mid;
    pulse_total_next       = decide ? '0 : total_mid;
  end

  // State commits only when a tick is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_since_edge  <= '0;
      ticks_since_pulse <= '0;
      pulse_total       <= '0;
    end else if (fire) begin
      ticks_since_edge  <= ticks_since_edge_next;
      ticks_since_pulse <= ticks_since_pulse_next;
      pulse_total       <= pulse_total_next;
    end
  end

endmodule

/* tb/denomination_checker.sv */
module denomination_checker
  import ptdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] edge_req, [1] poll
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [3:0] code
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  // Predicted copy of the decoder state and its registers
  cfg_t           cfg_regs;
  count_t         pulses;
  edge_ticks_t    since_edge;
  silence_ticks_t since_pulse;
  code_t          pending_codes[$];
  int             fail_count = 0;

  wire in_word    = s_axis_tvalid && s_axis_tready;
  wire out_word   = m_axis_tvalid && m_axis_tready;
  wire reg_write  = psel && penable && pready && pwrite;
  wire reg_read   = psel && penable && pready && !pwrite;

  // Each band limit that the count passes moves the code up by one;
  // past the last band it lands on out of range
  function automatic code_t denomination(count_t n);
    code_t c;
    c = CODE_IDLE;
    if (n >= BAND_MIN) c = c + 1'b1;
    if (n > BAND_1)    c = c + 1'b1;
    if (n > BAND_2)    c = c + 1'b1;
    if (n > BAND_3)    c = c + 1'b1;
    if (n > BAND_4)    c = c + 1'b1;
    if (n > BAND_5)    c = c + 1'b1;
    if (n > BAND_6)    c = c + 1'b1;
    if (n > BAND_7)    c = c + 1'b1;
    return c;
  endfunction

  // One tick: timers first, then the edge, then the poll
  task automatic advance_tick(input logic edge_bit, input logic poll_bit,
                              output code_t code);
    code = CODE_IDLE;
    if (since_edge != EDGE_MAX) since_edge = since_edge + 1'b1;
    if (since_pulse != SILENCE_MAX) since_pulse = since_pulse + 1'b1;
    if (edge_bit) begin
      if (since_edge > cfg_regs.lockout_ticks) begin
        if (pulses != COUNT_MAX) pulses = pulses + 1'b1;
        since_pulse = '0;
      end
      since_edge = '0;
    end
    if (poll_bit && pulses != '0 && since_pulse > cfg_regs.silence_ticks) begin
      code = denomination(pulses);
      pulses = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    code_t want_code;
    code_t new_code;
    logic [31:0] want_reg;
    if (rst) begin
      cfg_regs.lockout_ticks = LOCKOUT_RESET;
      cfg_regs.silence_ticks = SILENCE_RESET;
      pulses = '0;
      since_edge = '0;
      since_pulse = '0;
      pending_codes.delete();
    end else begin
      // Output word against the oldest prediction
      if (out_word) begin
        if (pending_codes.size() == 0) begin
          report_mismatch("output word with nothing pending", 32'(m_axis_tdata[3:0]),
                          32'd0);
        end else begin
          want_code = pending_codes.pop_front();
          if (m_axis_tdata[3:0] !== want_code)
            report_mismatch("code", 32'(m_axis_tdata[3:0]), 32'(want_code));
        end
      end
      // Register writes keep only the field bits
      if (reg_write) begin
        if (paddr == {REG_LOCKOUT, 2'b00}) cfg_regs.lockout_ticks = pwdata[7:0];
        else if (paddr == {REG_SILENCE, 2'b00}) cfg_regs.silence_ticks = pwdata[15:0];
      end
      if (reg_read) begin
        want_reg = (paddr == {REG_LOCKOUT, 2'b00}) ? {24'd0, cfg_regs.lockout_ticks}
                                                   : {16'd0, cfg_regs.silence_ticks};
        if (prdata !== want_reg) report_mismatch("register readback", prdata, want_reg);
      end
      if (in_word) begin
        advance_tick(s_axis_tdata[0], s_axis_tdata[1], new_code);
        pending_codes.push_back(new_code);
      end
    end
    mismatches <= fail_count;
    outstanding <= pending_codes.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import ptdd_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_TICKS = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] edge_req, [1] poll
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [3:0] code
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int idle_cycles;
  int sent_words;
  int taken_words;
  int lockout_now;
  int silence_now;
  bit hurry;
  bit send_burst;
  bit take_burst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pulse_train_denomination_decoder dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  denomination_checker code_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: random stalls, with stretches of none
  initial begin : take
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (taken_words % 40 == 0) take_burst = ($urandom_range(0, 2) == 0);
      stall = (hurry || take_burst) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken_words++;
    end
  end

  // One tick word; valid stays up when the next word follows with no gap
  task automatic send_tick(input bit edge_bit, input bit poll_bit);
    int gap;
    if (sent_words % 50 == 0) send_burst = ($urandom_range(0, 2) == 0);
    gap = (hurry || send_burst) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'($urandom), poll_bit, edge_bit};
    do @(posedge clk); while (!s_axis_tready);
    sent_words++;
  endtask

  task automatic idle_ticks(input int count, input int poll_pct);
    repeat (count) send_tick(1'b0, $urandom_range(0, 99) < poll_pct);
  endtask

  // Stop the input and wait for every predicted word to come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_access(input bit wr, input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers with junk above the fields, then read them back
  task automatic configure(input logic [7:0] lockout, input logic [15:0] silence);
    settle();
    apb_access(1'b1, REG_LOCKOUT, {24'($urandom), lockout});
    apb_access(1'b1, REG_SILENCE, {16'($urandom), silence});
    apb_access(1'b0, REG_LOCKOUT, 32'd0);
    apb_access(1'b0, REG_SILENCE, 32'd0);
    lockout_now = lockout;
    silence_now = silence;
  endtask

  // A note: n pulses spaced past the lockout, with the odd bounce inside it,
  // then silence and a poll (sometimes one tick too early first)
  task automatic pulse_train(input int n, input int in_poll_pct);
    for (int i = 0; i < n; i++) begin
      idle_ticks(lockout_now + $urandom_range(0, 2), in_poll_pct);
      send_tick(1'b1, 1'b0);
      if (lockout_now > 0 && $urandom_range(0, 7) == 0) begin
        idle_ticks($urandom_range(0, lockout_now - 1), in_poll_pct);
        send_tick(1'b1, 1'b0);
      end
    end
    if (silence_now > 0 && $urandom_range(0, 5) == 0) begin
      idle_ticks(silence_now - 1, 0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
    end else begin
      idle_ticks(silence_now + $urandom_range(0, 2), 0);
      send_tick(1'b0, 1'b1);
    end
  endtask

  initial begin : stimulus
    int start;
    int n;
    int pick;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    sent_words = 0;
    hurry = 1'b0;
    lockout_now = LOCKOUT_RESET;
    silence_now = SILENCE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: edge right after reset is locked out, empty poll
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    idle_ticks(3, 0);

    // No lockout, no silence: edge and poll together, then small counts
    configure(8'd0, 16'd0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (2) send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);

    // Lockout at all ones: saturated edge timer never passes it
    configure(8'hff, 16'd0);
    hurry = 1'b1;
    idle_ticks(258, 0);
    hurry = 1'b0;
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);

    // Largest usable lockout: one pulse just past it
    configure(8'd254, 16'd0);
    hurry = 1'b1;
    pulse_train(1, 0);
    hurry = 1'b0;

    // Silence near all ones: a short quiet stretch never decides
    configure(8'd0, 16'hffff);
    repeat (3) send_tick(1'b1, 1'b0);
    idle_ticks(20, 50);
    configure(8'd0, 16'hfffe);
    send_tick(1'b0, 1'b1);

    // Band edges from idle up into the seventh denomination, dense edges
    configure(8'd0, 16'd0);
    send_tick(1'b0, 1'b1);
    for (int k = 0; k < 13; k++) begin
      case (k)
        0: n = 1;      1: n = 2;      2: n = 3;      3: n = 8;
        4: n = 9;      5: n = 15;     6: n = 16;     7: n = 35;
        8: n = 36;     9: n = 85;     10: n = 86;    11: n = 166;
        default: n = 351;
      endcase
      hurry = (n > 100);
      repeat (n) send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
    end
    hurry = 1'b0;

    // Random notes under random short timings, with noise between them
    start = sent_words;
    while (sent_words - start < RANDOM_TICKS) begin
      configure($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(1, 6)),
                $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(1, 15)));
      repeat (2) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          repeat ($urandom_range(4, 20))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          if (pick < 7) n = $urandom_range(1, 20);
          else if (pick < 9) begin
            case ($urandom_range(0, 7))
              0: n = 2;   1: n = 3;   2: n = 8;   3: n = 9;
              4: n = 15;  5: n = 16;  6: n = 35;  default: n = 36;
            endcase
          end else n = $urandom_range(37, 90);
          pulse_train(n, 10);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
